>>> hw/rtl/acpd_pkg.sv
// Package for the attribute cell pixel decoder.
// Holds the display geometry constants, the colour table and the result struct.
// No dependencies.
package acpd_pkg;

    localparam int unsigned BORDER_TOP_LINES   = 24;
    localparam int unsigned DISPLAY_LINES      = 192;
    localparam int unsigned BORDER_LEFT_PIXELS = 32;
    localparam int unsigned DISPLAY_PIXELS     = 256;

    localparam int unsigned CELL_PIXELS = 8;
    localparam int unsigned WORD_W      = 6;

    typedef logic [WORD_W-1:0] rgb_word_t;

    typedef struct packed {
        rgb_word_t [CELL_PIXELS-1:0] pixel_word;
        logic                        in_display;
        logic [12:0]                 bitmap_offset;
        logic [9:0]                  attribute_offset;
    } cell_result_t;

    // Colour index (bright, G, R, B) to RGB222; normal level 2, bright level 3.
    function automatic rgb_word_t colour_word(input logic [3:0] idx);
        rgb_word_t w;
        begin
            unique case (idx)
                4'h0:    w = 6'h00;
                4'h1:    w = 6'h02;
                4'h2:    w = 6'h20;
                4'h3:    w = 6'h22;
                4'h4:    w = 6'h08;
                4'h5:    w = 6'h0a;
                4'h6:    w = 6'h28;
                4'h7:    w = 6'h2a;
                4'h8:    w = 6'h00;
                4'h9:    w = 6'h03;
                4'ha:    w = 6'h30;
                4'hb:    w = 6'h33;
                4'hc:    w = 6'h0c;
                4'hd:    w = 6'h0f;
                4'he:    w = 6'h3c;
                default: w = 6'h3f;
            endcase
            return w;
        end
    endfunction

endpackage

>>> hw/rtl/acpd_cell_decode.sv
// Combinational decode of one registered cell into pixel words and offsets.
// Depends on acpd_pkg.
module acpd_cell_decode (
    input  logic [7:0]            line,
    input  logic [5:0]            cell_column,
    input  logic [5:0]            frame_count,
    input  logic [3:0]            border_colour,
    input  logic [7:0]            pixel_byte,
    input  logic [7:0]            attr_byte,
    output acpd_pkg::cell_result_t result
);
    import acpd_pkg::*;

    localparam logic [8:0] ROW_LO = 9'(BORDER_TOP_LINES);
    localparam logic [8:0] ROW_HI = 9'(BORDER_TOP_LINES + DISPLAY_LINES);
    localparam logic [9:0] COL_LO = 10'(BORDER_LEFT_PIXELS);
    localparam logic [9:0] COL_HI = 10'(BORDER_LEFT_PIXELS + DISPLAY_PIXELS);

    logic [9:0]  x;
    logic [9:0]  x_rel;
    logic [8:0]  line_ext;
    logic [8:0]  v_full;
    logic [7:0]  v;
    logic [4:0]  col;
    logic        row_ok;
    logic        col_ok;
    logic [3:0]  paper;
    logic [3:0]  ink;
    logic [7:0]  pix;
    rgb_word_t   border_word;
    rgb_word_t   paper_word;
    rgb_word_t   ink_word;

    always_comb
    begin
        x        = {1'b0, cell_column, 3'b000};
        line_ext = {1'b0, line};
        row_ok   = (line_ext >= ROW_LO) && (line_ext < ROW_HI);
        col_ok   = (x >= COL_LO) && (x < COL_HI);
        v_full   = line_ext - ROW_LO;
        v        = v_full[7:0];
        x_rel    = x - COL_LO;
        col      = x_rel[7:3];

        paper = attr_byte[6:3];
        ink   = {attr_byte[6], attr_byte[2:0]};
        // Flash swaps ink and paper by inverting the bitmap.
        pix   = (attr_byte[7] && frame_count[5]) ? ~pixel_byte : pixel_byte;

        border_word = colour_word(border_colour);
        paper_word  = colour_word(paper);
        ink_word    = colour_word(ink);

        if (row_ok && col_ok)
        begin
            for (int k = 0; k < CELL_PIXELS; k++)
            begin
                result.pixel_word[k] = pix[CELL_PIXELS-1-k] ? ink_word : paper_word;
            end
            result.in_display       = 1'b1;
            // Low five bits of the interleaved base are zero, so the add is a join.
            result.bitmap_offset    = {v[7:6], v[2:0], v[5:3], col};
            result.attribute_offset = {v[7:3], col};
        end
        else
        begin
            for (int k = 0; k < CELL_PIXELS; k++)
            begin
                result.pixel_word[k] = border_word;
            end
            result.in_display       = 1'b0;
            result.bitmap_offset    = '0;
            result.attribute_offset = '0;
        end
    end

endmodule

>>> hw/rtl/attribute_cell_pixel_decoder_core.sv
// Attribute cell pixel decoder: one 8-pixel cell in, eight RGB222 words out.
// A taken word passes the input register, a shallow decode and the result
// register, then appears on the result ports with done high. Throughput: one
// word per cycle, busy stays low.
// Reset (rst_n, async, active low) clears the valid flags; no result follows.
// The receiver cannot stall: each result is shown for exactly one cycle.
module attribute_cell_pixel_decoder_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [7:0]          line,
    input  logic [5:0]          cell_column,
    input  logic [5:0]          frame_count,
    input  logic [3:0]          border_colour,
    input  logic [7:0]          pixel_byte,
    input  logic [7:0]          attr_byte,
    output logic                done,
    output acpd_pkg::rgb_word_t pixel_word_0,
    output acpd_pkg::rgb_word_t pixel_word_1,
    output acpd_pkg::rgb_word_t pixel_word_2,
    output acpd_pkg::rgb_word_t pixel_word_3,
    output acpd_pkg::rgb_word_t pixel_word_4,
    output acpd_pkg::rgb_word_t pixel_word_5,
    output acpd_pkg::rgb_word_t pixel_word_6,
    output acpd_pkg::rgb_word_t pixel_word_7,
    output logic                in_display,
    output logic [12:0]         bitmap_offset,
    output logic [9:0]          attribute_offset
);
    import acpd_pkg::*;

    // The pipeline never backs up, so a word is taken whenever start is high.
    logic accept;

    // Input register stage.
    logic       in_valid_reg;
    logic [7:0] line_reg;
    logic [5:0] cell_column_reg;
    logic [5:0] frame_count_reg;
    logic [3:0] border_colour_reg;
    logic [7:0] pixel_byte_reg;
    logic [7:0] attr_byte_reg;

    // Result register stage.
    cell_result_t decode_next;
    cell_result_t result_reg;
    logic         done_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg <= accept;
            done_reg     <= in_valid_reg;
        end
    end

    // Payload registers carry no reset; the valid flags qualify them.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            line_reg          <= line;
            cell_column_reg   <= cell_column;
            frame_count_reg   <= frame_count;
            border_colour_reg <= border_colour;
            pixel_byte_reg    <= pixel_byte;
            attr_byte_reg     <= attr_byte;
        end
        if (in_valid_reg)
        begin
            result_reg <= decode_next;
        end
    end

    acpd_cell_decode u_decode (
        .line          (line_reg),
        .cell_column   (cell_column_reg),
        .frame_count   (frame_count_reg),
        .border_colour (border_colour_reg),
        .pixel_byte    (pixel_byte_reg),
        .attr_byte     (attr_byte_reg),
        .result        (decode_next)
    );

    assign done             = done_reg;
    assign pixel_word_0     = result_reg.pixel_word[0];
    assign pixel_word_1     = result_reg.pixel_word[1];
    assign pixel_word_2     = result_reg.pixel_word[2];
    assign pixel_word_3     = result_reg.pixel_word[3];
    assign pixel_word_4     = result_reg.pixel_word[4];
    assign pixel_word_5     = result_reg.pixel_word[5];
    assign pixel_word_6     = result_reg.pixel_word[6];
    assign pixel_word_7     = result_reg.pixel_word[7];
    assign in_display       = result_reg.in_display;
    assign bitmap_offset    = result_reg.bitmap_offset;
    assign attribute_offset = result_reg.attribute_offset;

    // Every result traces back to a taken word that passed the input and result registers.
    a_done_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 2))
        else $error("result without a matching start");

    // A taken word always yields a result once it has passed both registers.
    a_start_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##2 done)
        else $error("accepted word produced no result");

    // Border cells share one colour; this checks zero offsets and pixel words 0 vs 7, 3 vs 4.
    a_border_uniform: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !in_display) |->
            (bitmap_offset == '0) && (attribute_offset == '0) &&
            (pixel_word_0 == pixel_word_7) && (pixel_word_3 == pixel_word_4))
        else $error("border cell with nonzero offset or mixed colours");

    // Attribute row and bitmap third/row fields come from the same display line; columns match.
    a_offsets_agree: assert property (@(posedge clk) disable iff (!rst_n)
        (done && in_display) |->
            (bitmap_offset[4:0] == attribute_offset[4:0]) &&
            (bitmap_offset[12:11] == attribute_offset[9:8]) &&
            (bitmap_offset[7:5] == attribute_offset[7:5]))
        else $error("bitmap and attribute offsets disagree");

endmodule

>>> bench/acpd_checker.sv
// Scoreboard for attribute_cell_pixel_decoder_core: predicts each accepted cell word.
// Compares every result word field by field. Depends on acpd_pkg.
`timescale 1ns / 1ps

module acpd_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  logic [7:0]          line,
    input  logic [5:0]          cell_column,
    input  logic [5:0]          frame_count,
    input  logic [3:0]          border_colour,
    input  logic [7:0]          pixel_byte,
    input  logic [7:0]          attr_byte,
    input  logic                done,
    input  acpd_pkg::rgb_word_t pixel_word_0,
    input  acpd_pkg::rgb_word_t pixel_word_1,
    input  acpd_pkg::rgb_word_t pixel_word_2,
    input  acpd_pkg::rgb_word_t pixel_word_3,
    input  acpd_pkg::rgb_word_t pixel_word_4,
    input  acpd_pkg::rgb_word_t pixel_word_5,
    input  acpd_pkg::rgb_word_t pixel_word_6,
    input  acpd_pkg::rgb_word_t pixel_word_7,
    input  logic                in_display,
    input  logic [12:0]         bitmap_offset,
    input  logic [9:0]          attribute_offset,
    output int                  mismatch_count,
    output int                  cells_in_flight
);
    import acpd_pkg::*;

    cell_result_t expected_cells[$];

    // Index is {bright, G, R, B}; each lit channel sits at level 2, or 3 when bright.
    function automatic rgb_word_t rgb_of(input logic [3:0] idx);
        logic [1:0] lvl;
        begin
            lvl = idx[3] ? 2'd3 : 2'd2;
            return {idx[1] ? lvl : 2'd0, idx[2] ? lvl : 2'd0, idx[0] ? lvl : 2'd0};
        end
    endfunction

    function automatic cell_result_t decode_cell(
        input logic [7:0] ln,
        input logic [5:0] cc,
        input logic [5:0] fc,
        input logic [3:0] bc,
        input logic [7:0] pb,
        input logic [7:0] ab
    );
        cell_result_t r;
        logic [8:0]   x;
        logic [7:0]   v;
        logic [4:0]   col;
        logic [3:0]   paper;
        logic [3:0]   ink;
        logic [7:0]   bits;
        begin
            x = {cc, 3'b000};
            if (ln >= BORDER_TOP_LINES && ln < BORDER_TOP_LINES + DISPLAY_LINES &&
                x >= BORDER_LEFT_PIXELS && x < BORDER_LEFT_PIXELS + DISPLAY_PIXELS)
            begin
                v     = 8'(ln - BORDER_TOP_LINES);
                col   = 5'((x - BORDER_LEFT_PIXELS) >> 3);
                paper = ab[6:3];
                ink   = {ab[6], ab[2:0]};
                // flash swaps ink and paper on the odd half of the flash period
                bits  = (ab[7] && fc[5]) ? ~pb : pb;
                for (int k = 0; k < CELL_PIXELS; k++)
                    r.pixel_word[k] = rgb_of(bits[7-k] ? ink : paper);
                r.in_display       = 1'b1;
                // screen interleave: third of screen, pixel row, char row, column
                r.bitmap_offset    = {v[7:6], v[2:0], v[5:3], col};
                r.attribute_offset = {v[7:3], col};
            end
            else
            begin
                for (int k = 0; k < CELL_PIXELS; k++)
                    r.pixel_word[k] = rgb_of(bc);
                r.in_display       = 1'b0;
                r.bitmap_offset    = '0;
                r.attribute_offset = '0;
            end
            return r;
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        begin
            $display("%0t ns: %s mismatch, got 0x%0h expected 0x%0h", $time, what, got, want);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        cell_result_t got;
        cell_result_t want;
        if (!rst_n)
        begin
            expected_cells.delete();
            mismatch_count  = 0;
            cells_in_flight = 0;
        end
        else
        begin
            if (done)
            begin
                got.pixel_word[0]    = pixel_word_0;
                got.pixel_word[1]    = pixel_word_1;
                got.pixel_word[2]    = pixel_word_2;
                got.pixel_word[3]    = pixel_word_3;
                got.pixel_word[4]    = pixel_word_4;
                got.pixel_word[5]    = pixel_word_5;
                got.pixel_word[6]    = pixel_word_6;
                got.pixel_word[7]    = pixel_word_7;
                got.in_display       = in_display;
                got.bitmap_offset    = bitmap_offset;
                got.attribute_offset = attribute_offset;
                if (expected_cells.size() == 0)
                    report_mismatch("unexpected result word", got.bitmap_offset, 0);
                else
                begin
                    want = expected_cells.pop_front();
                    for (int k = 0; k < CELL_PIXELS; k++)
                        if (got.pixel_word[k] !== want.pixel_word[k])
                            report_mismatch($sformatf("pixel_word_%0d", k),
                                            got.pixel_word[k], want.pixel_word[k]);
                    if (got.in_display !== want.in_display)
                        report_mismatch("in_display", got.in_display, want.in_display);
                    if (got.bitmap_offset !== want.bitmap_offset)
                        report_mismatch("bitmap_offset", got.bitmap_offset,
                                        want.bitmap_offset);
                    if (got.attribute_offset !== want.attribute_offset)
                        report_mismatch("attribute_offset", got.attribute_offset,
                                        want.attribute_offset);
                end
            end
            if (start && !busy)
                expected_cells.push_back(decode_cell(line, cell_column, frame_count,
                                                     border_colour, pixel_byte, attr_byte));
            cells_in_flight = expected_cells.size();
        end
    end

endmodule

>>> bench/tb_top.sv
// Top of the bench for attribute_cell_pixel_decoder_core: clock, reset, cell stimulus, verdict.
// Depends on acpd_pkg, the core and acpd_checker.
`timescale 1ns / 1ps

module tb_top;

    import acpd_pkg::*;

    localparam int RANDOM_CELLS  = 500;
    localparam int CALM_TAIL     = 60;   // last words go back to back, no gaps
    localparam int DRAIN_CYCLES  = 8;    // extra wait after the last predicted word to catch stray strobes

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [7:0]  line;
    logic [5:0]  cell_column;
    logic [5:0]  frame_count;
    logic [3:0]  border_colour;
    logic [7:0]  pixel_byte;
    logic [7:0]  attr_byte;
    logic        done;
    rgb_word_t   pixel_word_0;
    rgb_word_t   pixel_word_1;
    rgb_word_t   pixel_word_2;
    rgb_word_t   pixel_word_3;
    rgb_word_t   pixel_word_4;
    rgb_word_t   pixel_word_5;
    rgb_word_t   pixel_word_6;
    rgb_word_t   pixel_word_7;
    logic        in_display;
    logic [12:0] bitmap_offset;
    logic [9:0]  attribute_offset;
    int          mismatch_count;
    int          cells_in_flight;

    // 4 ns period
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    attribute_cell_pixel_decoder_core DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .line             (line),
        .cell_column      (cell_column),
        .frame_count      (frame_count),
        .border_colour    (border_colour),
        .pixel_byte       (pixel_byte),
        .attr_byte        (attr_byte),
        .done             (done),
        .pixel_word_0     (pixel_word_0),
        .pixel_word_1     (pixel_word_1),
        .pixel_word_2     (pixel_word_2),
        .pixel_word_3     (pixel_word_3),
        .pixel_word_4     (pixel_word_4),
        .pixel_word_5     (pixel_word_5),
        .pixel_word_6     (pixel_word_6),
        .pixel_word_7     (pixel_word_7),
        .in_display       (in_display),
        .bitmap_offset    (bitmap_offset),
        .attribute_offset (attribute_offset)
    );

    acpd_checker scoreboard (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .line             (line),
        .cell_column      (cell_column),
        .frame_count      (frame_count),
        .border_colour    (border_colour),
        .pixel_byte       (pixel_byte),
        .attr_byte        (attr_byte),
        .done             (done),
        .pixel_word_0     (pixel_word_0),
        .pixel_word_1     (pixel_word_1),
        .pixel_word_2     (pixel_word_2),
        .pixel_word_3     (pixel_word_3),
        .pixel_word_4     (pixel_word_4),
        .pixel_word_5     (pixel_word_5),
        .pixel_word_6     (pixel_word_6),
        .pixel_word_7     (pixel_word_7),
        .in_display       (in_display),
        .bitmap_offset    (bitmap_offset),
        .attribute_offset (attribute_offset),
        .mismatch_count   (mismatch_count),
        .cells_in_flight  (cells_in_flight)
    );

    // Presents one cell word and holds it until an edge with busy low takes it.
    // Called right after a rising edge; returns right after the accepting edge,
    // so back-to-back calls keep start high without a glitch.
    task automatic send_cell(
        input logic [7:0] ln,
        input logic [5:0] cc,
        input logic [5:0] fc,
        input logic [3:0] bc,
        input logic [7:0] pb,
        input logic [7:0] ab
    );
        begin
            start         <= 1'b1;
            line          <= ln;
            cell_column   <= cc;
            frame_count   <= fc;
            border_colour <= bc;
            pixel_byte    <= pb;
            attr_byte     <= ab;
            @(posedge clk);
            while (busy)
                @(posedge clk);
        end
    endtask

    // Sender gap: start low, fields scrambled so ignored inputs get exercised too.
    task automatic idle_cycles(input int n);
        begin
            start         <= 1'b0;
            line          <= 8'($urandom);
            cell_column   <= 6'($urandom);
            frame_count   <= 6'($urandom);
            border_colour <= 4'($urandom);
            pixel_byte    <= 8'($urandom);
            attr_byte     <= 8'($urandom);
            repeat (n) @(posedge clk);
        end
    endtask

    // Random cell, mostly inside the display window; the rest hits the border
    // and field values past the nominal 320x240 frame.
    task automatic send_random_cell();
        logic [7:0] ln;
        logic [5:0] cc;
        int         pick;
        begin
            pick = $urandom_range(0, 99);
            if (pick < 75)
                ln = 8'($urandom_range(BORDER_TOP_LINES, BORDER_TOP_LINES + DISPLAY_LINES - 1));
            else if (pick < 93)
                ln = 8'($urandom_range(0, 239));
            else
                ln = 8'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 75)
                cc = 6'($urandom_range(BORDER_LEFT_PIXELS / 8,
                                       (BORDER_LEFT_PIXELS + DISPLAY_PIXELS) / 8 - 1));
            else if (pick < 93)
                cc = 6'($urandom_range(0, 39));
            else
                cc = 6'($urandom);
            send_cell(ln, cc, 6'($urandom), 4'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        start         = 1'b0;
        line          = '0;
        cell_column   = '0;
        frame_count   = '0;
        border_colour = '0;
        pixel_byte    = '0;
        attr_byte     = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed cells ---
        // border corners and edges, dim and bright border colours
        send_cell(8'd0,   6'd0,  6'd0,  4'h0, 8'hff, 8'hff);
        send_cell(8'd23,  6'd10, 6'd0,  4'h7, 8'hff, 8'h00);
        send_cell(8'd24,  6'd3,  6'd0,  4'h8, 8'h00, 8'h00);  // just left of display
        send_cell(8'd216, 6'd20, 6'd63, 4'hf, 8'ha5, 8'hc7);  // first line below display
        send_cell(8'd239, 6'd39, 6'd0,  4'h9, 8'h00, 8'hff);
        // fields past the nominal frame are border
        send_cell(8'd255, 6'd20, 6'd32, 4'h5, 8'h5a, 8'h80);
        send_cell(8'd100, 6'd36, 6'd0,  4'ha, 8'hff, 8'h3f);  // right border
        send_cell(8'd100, 6'd63, 6'd0,  4'h2, 8'hff, 8'h3f);
        idle_cycles(2);
        // display corners: offsets at their minimum and maximum
        send_cell(8'd24,  6'd4,  6'd0,  4'h3, 8'h80, 8'h38);
        send_cell(8'd24,  6'd35, 6'd0,  4'h3, 8'h01, 8'h07);
        send_cell(8'd215, 6'd4,  6'd0,  4'h4, 8'hf0, 8'h47);
        send_cell(8'd215, 6'd35, 6'd0,  4'h4, 8'h0f, 8'h78);
        // each interleave field of the vertical position on its own
        send_cell(8'd31,  6'd12, 6'd0,  4'h6, 8'hcc, 8'h16);
        send_cell(8'd80,  6'd12, 6'd0,  4'h6, 8'h33, 8'h29);
        send_cell(8'd152, 6'd12, 6'd0,  4'h6, 8'h81, 8'h4e);
        // flash: attr bit set or clear, frame phase set or clear
        send_cell(8'd50,  6'd8,  6'd31, 4'h1, 8'ha5, 8'h8a);
        send_cell(8'd50,  6'd8,  6'd32, 4'h1, 8'ha5, 8'h8a);
        send_cell(8'd50,  6'd8,  6'd63, 4'h1, 8'ha5, 8'h0a);
        send_cell(8'd50,  6'd8,  6'd63, 4'h1, 8'ha5, 8'hcf);
        // bright black stays black, full bright white
        send_cell(8'd60,  6'd17, 6'd0,  4'hb, 8'h55, 8'h40);
        send_cell(8'd60,  6'd17, 6'd0,  4'hc, 8'h55, 8'h7f);
        send_cell(8'd60,  6'd17, 6'd0,  4'hd, 8'h00, 8'hbf);
        idle_cycles(1);

        // --- random cells; gaps in bursts, none in the calm tail ---
        for (int n = 0; n < RANDOM_CELLS; n++)
        begin
            if (n < RANDOM_CELLS - CALM_TAIL && $urandom_range(0, 3) == 0)
                idle_cycles($urandom_range(1, 6));
            send_random_cell();
        end
        start <= 1'b0;

        // drain: wait for every predicted word, then catch any stray strobe
        @(posedge clk);
        while (cells_in_flight != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog: ends a hung run with a failure verdict.
    initial
    begin
        #1_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
